// File: rtl/tsgd_pkg.sv
package tsgd_pkg;

   localparam int COORD_X_BITS = 11;
   localparam int COORD_Y_BITS = 10;
   localparam int DIST_BITS    = 13;
   localparam int COUNT_BITS   = 2;
   localparam int ID_BITS      = 7;
   localparam int CSR_ADDR_BITS = 2;

   // Comparison width: wide enough for any magnitude and any threshold.
   localparam int CMP_BITS =
      (COORD_X_BITS > COORD_Y_BITS ?
         (COORD_X_BITS > DIST_BITS ? COORD_X_BITS : DIST_BITS) :
         (COORD_Y_BITS > DIST_BITS ? COORD_Y_BITS : DIST_BITS)) + 1;

   localparam int REQ_FIELD_BITS = COUNT_BITS + ID_BITS + COORD_X_BITS + COORD_Y_BITS + 1;
   localparam int REQ_DATA_BITS  = ((REQ_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS  = 8;

   localparam logic [DIST_BITS-1:0] MIN_SWIPE_RESET  = DIST_BITS'(200);
   localparam logic [DIST_BITS-1:0] MIN_CHANGE_RESET = DIST_BITS'(120);
   localparam logic [DIST_BITS-1:0] MAX_CHANGE_RESET = DIST_BITS'(500);

   typedef enum logic [2:0] {
      DIR_NONE  = 3'd0,
      DIR_LEFT  = 3'd1,
      DIR_RIGHT = 3'd2,
      DIR_UP    = 3'd3,
      DIR_DOWN  = 3'd4
   } dir_type;

   typedef enum logic [CSR_ADDR_BITS-1:0] {
      CSR_MIN_SWIPE    = 2'd0,
      CSR_MIN_CHANGE   = 2'd1,
      CSR_MAX_CHANGE   = 2'd2,
      CSR_ALLOW_CHANGE = 2'd3
   } csr_addr_type;

   typedef struct packed {
      logic [DIST_BITS-1:0] min_swipe;
      logic [DIST_BITS-1:0] min_change;
      logic [DIST_BITS-1:0] max_change;
      logic                 allow_change;
   } cfg_type;

   typedef struct packed {
      logic [COUNT_BITS-1:0]   touch_count;
      logic [ID_BITS-1:0]      touch_id;
      logic [COORD_X_BITS-1:0] touch_x;
      logic [COORD_Y_BITS-1:0] touch_y;
      logic                    pad_click;
   } sample_type;

   typedef struct packed {
      dir_type                 held_dir;
      dir_type                 done_dir;
      logic                    blocked_valid;
      logic [ID_BITS-1:0]      blocked_id;
      logic                    previous_valid;
      logic [ID_BITS-1:0]      previous_id;
      logic [COORD_X_BITS-1:0] start_x;
      logic [COORD_Y_BITS-1:0] start_y;
      logic                    multi_touch;
      logic                    dir_locked;
   } gesture_type;

   typedef struct packed {
      dir_type current_dir;
      dir_type final_dir;
   } result_type;

endpackage

// File: rtl/tsgd_step.sv
module tsgd_step import tsgd_pkg::*; (
   input  gesture_type state,
   input  cfg_type     cfg,
   input  sample_type  sample,
   output gesture_type next_state
);

   logic signed [COORD_X_BITS:0] dx;
   logic signed [COORD_Y_BITS:0] dy;
   logic [CMP_BITS-1:0]          ax;
   logic [CMP_BITS-1:0]          ay;
   logic [CMP_BITS-1:0]          lim;
   logic [CMP_BITS-1:0]          max_lim;
   logic                         blocked_now;
   logic [ID_BITS-1:0]           blocked_id_now;
   dir_type                      dir;

   always_comb begin
      dx = $signed({1'b0, sample.touch_x}) - $signed({1'b0, state.start_x});
      dy = $signed({1'b0, sample.touch_y}) - $signed({1'b0, state.start_y});
      ax = dx[COORD_X_BITS] ? CMP_BITS'(-dx) : CMP_BITS'(dx);
      ay = dy[COORD_Y_BITS] ? CMP_BITS'(-dy) : CMP_BITS'(dy);
      lim = (state.held_dir == DIR_NONE) ? CMP_BITS'(cfg.min_swipe) : CMP_BITS'(cfg.min_change);
      max_lim = CMP_BITS'(cfg.max_change);

      // Vertical wins a tie; a zero offset counts as right or down.
      if (ax > ay) begin
         dir = dx[COORD_X_BITS] ? DIR_LEFT : DIR_RIGHT;
      end else begin
         dir = dy[COORD_Y_BITS] ? DIR_UP : DIR_DOWN;
      end

      blocked_now    = state.blocked_valid | sample.pad_click;
      blocked_id_now = sample.pad_click ? sample.touch_id : state.blocked_id;
   end

   always_comb begin
      next_state = state;
      if (sample.touch_count == '0) begin
         next_state.multi_touch    = 1'b0;
         next_state.previous_valid = 1'b0;
         next_state.done_dir       = state.held_dir;
         next_state.blocked_valid  = 1'b0;
         next_state.held_dir       = DIR_NONE;
         next_state.dir_locked     = 1'b0;
      end else if (!state.multi_touch && sample.touch_count == COUNT_BITS'(1)) begin
         next_state.blocked_valid = blocked_now;
         next_state.blocked_id    = blocked_id_now;
         next_state.done_dir      = DIR_NONE;
         if (blocked_now && sample.touch_id == blocked_id_now) begin
            next_state.held_dir = DIR_NONE;
         end else if (!state.previous_valid || sample.touch_id != state.previous_id) begin
            next_state.previous_valid = 1'b1;
            next_state.previous_id    = sample.touch_id;
            next_state.start_x        = sample.touch_x;
            next_state.start_y        = sample.touch_y;
         end else if (state.held_dir != DIR_NONE && (ax > max_lim || ay > max_lim)) begin
            next_state.dir_locked = 1'b1;
         end else if (ax > lim || ay > lim) begin
            if (state.held_dir == DIR_NONE) begin
               next_state.held_dir = dir;
            end else if (dir != state.held_dir) begin
               if (cfg.allow_change && !state.dir_locked) begin
                  next_state.held_dir = dir;
               end else begin
                  // Change not permitted: finish the swipe and ignore this touch.
                  next_state.done_dir      = state.held_dir;
                  next_state.blocked_valid = 1'b1;
                  next_state.blocked_id    = sample.touch_id;
               end
            end
         end
      end else begin
         next_state.multi_touch = 1'b1;
      end
   end

endmodule

// File: rtl/tsgd_out_buf.sv
module tsgd_out_buf import tsgd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  result_type in_data,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_data
);

   result_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   logic       pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign push      = in_valid & in_ready;
   assign pop       = out_valid & out_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

// File: rtl/touch_swipe_gesture_detector_core.sv
// Single-finger swipe detector for touchpad samples. Each req beat carries one
// sample; exactly one rsp beat follows it with the held and the completed
// direction after that sample. A sample is evaluated in the cycle it is
// accepted (subtract, magnitude and threshold compare against the recorded
// start point) and its result is registered in a two-entry output buffer, so
// one sample per cycle is sustained unless the buffer is full. req_tready
// drops only when both buffer entries hold results not yet taken. The user must
// write thresholds over csr only while no sample is in flight (not enforced).
module touch_swipe_gesture_detector_core import tsgd_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // touch_count, touch_id, touch_x, touch_y, pad_click, zero fill
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // current_direction, final_direction, zero fill
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,
   input  logic                     csr_we,
   input  logic [CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [DIST_BITS-1:0]     csr_wdata
);

   cfg_type     cfg_ff, cfg_in;
   gesture_type state_ff;
   gesture_type state_in;
   sample_type  sample;
   result_type  result;
   result_type  out_result;
   logic        accept;

   always_comb begin
      sample.touch_count = req_tdata[COUNT_BITS-1:0];
      sample.touch_id    = req_tdata[COUNT_BITS +: ID_BITS];
      sample.touch_x     = req_tdata[COUNT_BITS+ID_BITS +: COORD_X_BITS];
      sample.touch_y     = req_tdata[COUNT_BITS+ID_BITS+COORD_X_BITS +: COORD_Y_BITS];
      sample.pad_click   = req_tdata[COUNT_BITS+ID_BITS+COORD_X_BITS+COORD_Y_BITS];
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_MIN_SWIPE:    cfg_in.min_swipe    = csr_wdata;
            CSR_MIN_CHANGE:   cfg_in.min_change   = csr_wdata;
            CSR_MAX_CHANGE:   cfg_in.max_change   = csr_wdata;
            CSR_ALLOW_CHANGE: cfg_in.allow_change = csr_wdata[0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_swipe    <= MIN_SWIPE_RESET;
         cfg_ff.min_change   <= MIN_CHANGE_RESET;
         cfg_ff.max_change   <= MAX_CHANGE_RESET;
         cfg_ff.allow_change <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tsgd_step u_step (
      .state      (state_ff),
      .cfg        (cfg_ff),
      .sample     (sample),
      .next_state (state_in)
   );

   assign accept = req_tvalid & req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

   assign result.current_dir = state_in.held_dir;
   assign result.final_dir   = state_in.done_dir;

   tsgd_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (result),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_result)
   );

   assign rsp_tdata = {2'b00, out_result.final_dir, out_result.current_dir};

endmodule
